>>> src/cau_pkg.sv
package cau_pkg;

  localparam int WORD_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int CMD_BITS      = 3;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_ADD = 3'd0,
    CMD_SUB = 3'd1,
    CMD_MUL = 3'd2,
    CMD_DIV = 3'd3,
    CMD_NEG = 3'd4
  } cmd_t;

endpackage

>>> src/complex_arithmetic_unit.sv
// Every operation takes the same path from input transfer to output transfer.
// Throughput: one transfer per cycle; the divider is one quotient bit per stage,
// 2*WORD_BITS + FRAC_BITS + 1 stages, and the whole pipeline holds as one on back-pressure.
// Reset: rst is synchronous, active high; it clears the valid bits of all stages.
// No clearing pass; s_tready is high in the first cycle after reset.
module complex_arithmetic_unit #(
  parameter int WORD_BITS = cau_pkg::WORD_BITS_DEF,
  parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     s_tvalid,
  output logic                                     s_tready,
  // a_re, a_im, b_re, b_im (lowest first), zero pad to bytes
  input  logic [((4*WORD_BITS+7)/8)*8-1:0]         s_tdata,
  // cmd
  input  logic [cau_pkg::CMD_BITS-1:0]             s_tuser,
  output logic                                     m_tvalid,
  input  logic                                     m_tready,
  // res_re, res_im (lowest first), zero pad to bytes
  output logic [((2*WORD_BITS+7)/8)*8-1:0]         m_tdata,
  // saturated, divide_by_zero (lowest first)
  output logic [1:0]                               m_tuser
);

  import cau_pkg::*;

  localparam int W   = WORD_BITS;
  localparam int F   = FRAC_BITS;
  localparam int PW  = 2 * W;           // signed product
  localparam int SW  = 2 * W + 1;       // signed cross sum
  localparam int DW  = 2 * W;           // squared magnitude, unsigned
  localparam int NW  = 2 * W + F + 1;   // numerator magnitude and quotient
  localparam int ODW = ((2 * W + 7) / 8) * 8;

  localparam logic signed [SW-1:0] SMAX = (SW'(1) <<< (W - 1)) - SW'(1);
  localparam logic signed [SW-1:0] SMIN = -(SW'(1) <<< (W - 1));
  localparam logic [NW-1:0]        QHALF = NW'(1) << (W - 1);
  localparam logic [W-1:0]         WMAX  = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0]         WMIN  = {1'b1, {(W-1){1'b0}}};

  // Clip a signed value to the word range; returns {flag, value}.
  function automatic logic [W:0] clip_s(input logic signed [SW-1:0] v);
    logic [W:0] r;
    if (v > SMAX) begin
      r = {1'b1, WMAX};
    end else if (v < SMIN) begin
      r = {1'b1, WMIN};
    end else begin
      r = {1'b0, v[W-1:0]};
    end
    return r;
  endfunction

  // Whole pipeline advances together; s_tready follows the output register and m_tready.
  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // ---------------- Stage A: capture operands ----------------
  logic                va_v;
  cmd_t                va_cmd;
  logic signed [W-1:0] ar, ai, br, bi;

  always_ff @(posedge clk) begin
    if (en) begin
      va_cmd <= cmd_t'(s_tuser);
      ar     <= s_tdata[W-1:0];
      ai     <= s_tdata[2*W-1:W];
      br     <= s_tdata[3*W-1:2*W];
      bi     <= s_tdata[4*W-1:3*W];
    end
    if (rst) begin
      va_v <= 1'b0;
    end else if (en) begin
      va_v <= s_tvalid;
    end
  end

  // ---------------- Stage B: products and direct results ----------------
  logic                 vb_v;
  cmd_t                 vb_cmd;
  logic signed [PW-1:0] pa, pb, pc, pd, pe, pf;
  logic signed [W:0]    sr, si;
  logic signed [W:0]    sr_next, si_next;

  always_comb begin
    case (va_cmd)
      CMD_ADD: begin
        sr_next = (W+1)'(ar) + (W+1)'(br);
        si_next = (W+1)'(ai) + (W+1)'(bi);
      end
      CMD_SUB: begin
        sr_next = (W+1)'(ar) - (W+1)'(br);
        si_next = (W+1)'(ai) - (W+1)'(bi);
      end
      CMD_NEG: begin
        sr_next = -((W+1)'(ar));
        si_next = -((W+1)'(ai));
      end
      default: begin
        sr_next = '0;
        si_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vb_cmd <= va_cmd;
      pa     <= PW'(ar) * PW'(br);
      pb     <= PW'(ai) * PW'(bi);
      pc     <= PW'(ai) * PW'(br);
      pd     <= PW'(ar) * PW'(bi);
      pe     <= PW'(br) * PW'(br);
      pf     <= PW'(bi) * PW'(bi);
      sr     <= sr_next;
      si     <= si_next;
    end
    if (rst) begin
      vb_v <= 1'b0;
    end else if (en) begin
      vb_v <= va_v;
    end
  end

  // ---------------- Stage C: cross sums, product results ----------------
  logic                 vc_v;
  logic                 vc_div;
  logic signed [SW-1:0] xr, xi;
  logic [DW-1:0]        dd;
  logic [W-1:0]         pre_re_c, pre_im_c;
  logic                 pre_sat_c;

  logic signed [SW-1:0] mr, mi, nr, ni, mr_sh, mi_sh;
  logic [W:0]           cl_re, cl_im;
  logic [W-1:0]         pre_re_next, pre_im_next;
  logic                 pre_sat_next;

  always_comb begin
    mr    = SW'(pa) - SW'(pb);
    mi    = SW'(pc) + SW'(pd);
    nr    = SW'(pa) + SW'(pb);
    ni    = SW'(pc) - SW'(pd);
    mr_sh = mr >>> F;
    mi_sh = mi >>> F;
    case (vb_cmd)
      CMD_MUL: begin
        cl_re = clip_s(mr_sh);
        cl_im = clip_s(mi_sh);
      end
      CMD_ADD, CMD_SUB, CMD_NEG: begin
        cl_re = clip_s(SW'(sr));
        cl_im = clip_s(SW'(si));
      end
      default: begin
        cl_re = '0;
        cl_im = '0;
      end
    endcase
    pre_re_next  = cl_re[W-1:0];
    pre_im_next  = cl_im[W-1:0];
    pre_sat_next = cl_re[W] | cl_im[W];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vc_div    <= (vb_cmd == CMD_DIV);
      xr        <= nr;
      xi        <= ni;
      dd        <= DW'($unsigned(pe)) + DW'($unsigned(pf));
      pre_re_c  <= pre_re_next;
      pre_im_c  <= pre_im_next;
      pre_sat_c <= pre_sat_next;
    end
    if (rst) begin
      vc_v <= 1'b0;
    end else if (en) begin
      vc_v <= vb_v;
    end
  end

  // ---------------- Divider: one quotient bit per stage ----------------
  logic          dv_v    [0:NW];
  logic          dv_div  [0:NW];
  logic          dv_negr [0:NW];
  logic          dv_negi [0:NW];
  logic [DW-1:0] dv_d    [0:NW];
  logic [NW-1:0] dv_nr   [0:NW];
  logic [NW-1:0] dv_ni   [0:NW];
  logic [DW-1:0] dv_rr   [0:NW];
  logic [DW-1:0] dv_ri   [0:NW];
  logic [NW-1:0] dv_qr   [0:NW];
  logic [NW-1:0] dv_qi   [0:NW];
  logic [W-1:0]  dv_pre  [0:NW];
  logic [W-1:0]  dv_pim  [0:NW];
  logic          dv_psat [0:NW];

  logic [SW-1:0] mag_r, mag_i;
  assign mag_r = xr[SW-1] ? SW'(-xr) : SW'(xr);
  assign mag_i = xi[SW-1] ? SW'(-xi) : SW'(xi);

  always_ff @(posedge clk) begin
    if (en) begin
      dv_div[0]  <= vc_div;
      dv_negr[0] <= xr[SW-1];
      dv_negi[0] <= xi[SW-1];
      dv_d[0]    <= dd;
      dv_nr[0]   <= NW'(mag_r) << F;
      dv_ni[0]   <= NW'(mag_i) << F;
      dv_rr[0]   <= '0;
      dv_ri[0]   <= '0;
      dv_qr[0]   <= '0;
      dv_qi[0]   <= '0;
      dv_pre[0]  <= pre_re_c;
      dv_pim[0]  <= pre_im_c;
      dv_psat[0] <= pre_sat_c;
    end
    if (rst) begin
      dv_v[0] <= 1'b0;
    end else if (en) begin
      dv_v[0] <= vc_v;
    end
  end

  for (genvar s = 0; s < NW; s++) begin : g_div
    logic [DW:0] tr, ti, dr, di;
    logic        ger, gei;
    always_comb begin
      tr  = {dv_rr[s], dv_nr[s][NW-1]};
      ti  = {dv_ri[s], dv_ni[s][NW-1]};
      dr  = tr - {1'b0, dv_d[s]};
      di  = ti - {1'b0, dv_d[s]};
      ger = (tr >= {1'b0, dv_d[s]});
      gei = (ti >= {1'b0, dv_d[s]});
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dv_div[s+1]  <= dv_div[s];
        dv_negr[s+1] <= dv_negr[s];
        dv_negi[s+1] <= dv_negi[s];
        dv_d[s+1]    <= dv_d[s];
        dv_nr[s+1]   <= dv_nr[s] << 1;
        dv_ni[s+1]   <= dv_ni[s] << 1;
        dv_rr[s+1]   <= ger ? dr[DW-1:0] : tr[DW-1:0];
        dv_ri[s+1]   <= gei ? di[DW-1:0] : ti[DW-1:0];
        dv_qr[s+1]   <= {dv_qr[s][NW-2:0], ger};
        dv_qi[s+1]   <= {dv_qi[s][NW-2:0], gei};
        dv_pre[s+1]  <= dv_pre[s];
        dv_pim[s+1]  <= dv_pim[s];
        dv_psat[s+1] <= dv_psat[s];
      end
      if (rst) begin
        dv_v[s+1] <= 1'b0;
      end else if (en) begin
        dv_v[s+1] <= dv_v[s];
      end
    end
  end

  // ---------------- Output: sign, clip, select ----------------
  logic [W-1:0]  res_re_next, res_im_next, qv_re, qv_im;
  logic          sat_next, dz_next, qs_re, qs_im;
  logic [NW-1:0] qr_f, qi_f;

  assign qr_f = dv_qr[NW];
  assign qi_f = dv_qi[NW];

  always_comb begin
    if (dv_negr[NW]) begin
      qs_re = (qr_f > QHALF);
      qv_re = qs_re ? WMIN : W'(-qr_f);
    end else begin
      qs_re = (qr_f >= QHALF);
      qv_re = qs_re ? WMAX : qr_f[W-1:0];
    end
    if (dv_negi[NW]) begin
      qs_im = (qi_f > QHALF);
      qv_im = qs_im ? WMIN : W'(-qi_f);
    end else begin
      qs_im = (qi_f >= QHALF);
      qv_im = qs_im ? WMAX : qi_f[W-1:0];
    end
    dz_next = 1'b0;
    if (!dv_div[NW]) begin
      res_re_next = dv_pre[NW];
      res_im_next = dv_pim[NW];
      sat_next    = dv_psat[NW];
    end else if (dv_d[NW] == '0) begin
      // zero divisor: zero result, flag only the divide
      res_re_next = '0;
      res_im_next = '0;
      sat_next    = 1'b0;
      dz_next     = 1'b1;
    end else begin
      res_re_next = qv_re;
      res_im_next = qv_im;
      sat_next    = qs_re | qs_im;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= ODW'({res_im_next, res_re_next});
      m_tuser <= {dz_next, sat_next};
    end
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= dv_v[NW];
    end
  end

endmodule

>>> src/cau_check.sv
module cau_check #(
  parameter int ODW = 64
) (
  input logic           clk,
  input logic           rst,
  input logic           s_tready,
  input logic           m_tvalid,
  input logic           m_tready,
  input logic [ODW-1:0] m_tdata,
  input logic [1:0]     m_tuser
);

  // hold a result until it is taken
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("output transfer dropped or changed while stalled");

  // input side is open exactly when the output register can advance
  assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("input ready does not follow output register state");

  // zero divisor gives zero and no saturation
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> !m_tuser[0] && (m_tdata == '0))
    else $error("divide by zero result not clean");

  // nothing leaves right after reset
  assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule

bind complex_arithmetic_unit cau_check #(.ODW(ODW)) u_cau_check (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

>>> verif/complex_arithmetic_unit_tb.sv
`timescale 1ns / 100ps

module complex_arithmetic_unit_tb;
  import cau_pkg::*;

  localparam int WB = cau_pkg::WORD_BITS_DEF;
  localparam int FB = cau_pkg::FRAC_BITS_DEF;
  localparam int LATENCY = 2 * WB + FB + 6;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_ITEMS = 400;

  typedef struct packed {
    logic [WB-1:0] re;
    logic [WB-1:0] im;
    logic          sat;
    logic          dz;
  } cplx_result_t;

  // Tracks the results the unit owes us, oldest first.
  class cplx_scoreboard;
    cplx_result_t pending[$];
    int mismatches;
    int checked;
    int div_zero_seen;
    int sat_seen;

    // Clip a wide signed value to the word range, setting the flag on clipping.
    function automatic logic [WB-1:0] clip(input logic signed [255:0] v, inout logic flag);
      logic signed [255:0] hi;
      logic signed [255:0] lo;
      hi = (256'sd1 <<< (WB - 1)) - 1;
      lo = -(256'sd1 <<< (WB - 1));
      if (v > hi) begin
        flag = 1'b1;
        return hi[WB-1:0];
      end
      if (v < lo) begin
        flag = 1'b1;
        return lo[WB-1:0];
      end
      return v[WB-1:0];
    endfunction

    // Truncating division of a signed numerator by a positive divisor.
    function automatic logic signed [255:0] div_trunc(input logic signed [255:0] n,
                                                      input logic signed [255:0] d);
      logic signed [255:0] q;
      q = (n < 0) ? -((-n) / d) : n / d;
      return q;
    endfunction

    function void note_operands(input logic [2:0] cmd, input logic [WB-1:0] ar,
                                input logic [WB-1:0] ai, input logic [WB-1:0] br,
                                input logic [WB-1:0] bi);
      logic signed [255:0] xr, xi, yr, yi, rr, ri, mag;
      cplx_result_t r;
      xr = $signed(ar);
      xi = $signed(ai);
      yr = $signed(br);
      yi = $signed(bi);
      rr = '0;
      ri = '0;
      r = '0;
      case (cmd)
        CMD_ADD: begin
          rr = xr + yr;
          ri = xi + yi;
        end
        CMD_SUB: begin
          rr = xr - yr;
          ri = xi - yi;
        end
        CMD_MUL: begin
          rr = (xr * yr - xi * yi) >>> FB;
          ri = (xi * yr + xr * yi) >>> FB;
        end
        CMD_DIV: begin
          mag = yr * yr + yi * yi;
          if (mag == 0) begin
            r.dz = 1'b1;
          end else begin
            rr = div_trunc((xr * yr + xi * yi) <<< FB, mag);
            ri = div_trunc((xi * yr - xr * yi) <<< FB, mag);
          end
        end
        CMD_NEG: begin
          rr = -xr;
          ri = -xi;
        end
        default: begin
        end
      endcase
      r.re = clip(rr, r.sat);
      r.im = clip(ri, r.sat);
      pending.push_back(r);
    endfunction

    function void check_result(input cplx_result_t got);
      cplx_result_t want;
      checked++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected result %h", got);
        return;
      end
      want = pending.pop_front();
      if (got.sat) sat_seen++;
      if (got.dz) div_zero_seen++;
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: result %0d: expected re=%h im=%h sat=%b dz=%b, got re=%h im=%h sat=%b dz=%b",
                   checked, want.re, want.im, want.sat, want.dz,
                   got.re, got.im, got.sat, got.dz);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [((4*WB+7)/8)*8-1:0] s_tdata = '0;
  logic [CMD_BITS-1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [((2*WB+7)/8)*8-1:0] m_tdata;
  logic [1:0] m_tuser;

  cplx_scoreboard board;
  int cycles = 0;
  bit hold_off = 1'b0;
  int sent = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  complex_arithmetic_unit dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  // Mostly short gaps, now and then a long one.
  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [WB-1:0] rand_word();
    logic [WB-1:0] w;
    case ($urandom_range(0, 5))
      0: w = {1'b1, {(WB-1){1'b0}}};
      1: w = {1'b0, {(WB-1){1'b1}}};
      2: w = $signed($urandom_range(0, 8 << FB)) - (4 << FB);
      3: w = '0;
      default: w = $urandom();
    endcase
    return w;
  endfunction

  // Offer one operand set and hold it until the transfer completes.
  task automatic send_op(input logic [2:0] cmd, input logic [WB-1:0] ar,
                         input logic [WB-1:0] ai, input logic [WB-1:0] br,
                         input logic [WB-1:0] bi);
    int g;
    g = gap_len();
    if (g > 0) begin
      s_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= cmd;
    s_tdata <= {bi, br, ai, ar};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    board.note_operands(cmd, ar, ai, br, bi);
    sent++;
  endtask

  // Output side: random stalls, plus one long hold-off requested by the sender.
  initial begin
    int g;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready)
        board.check_result({m_tdata[WB-1:0], m_tdata[2*WB-1:WB], m_tuser[0], m_tuser[1]});
      if (hold_off) begin
        m_tready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
        m_tready <= 1'b1;
      end else begin
        g = gap_len();
        if (g > 0) begin
          m_tready <= 1'b0;
          repeat (g - 1) @(posedge clk);
        end else begin
          m_tready <= 1'b1;
        end
      end
    end
  end

  // Give up on a hung run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  logic [WB-1:0] maxw, minw, one;
  logic [2:0] k;

  initial begin
    board = new();
    maxw = {1'b0, {(WB-1){1'b1}}};
    minw = {1'b1, {(WB-1){1'b0}}};
    one = 1 << FB;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extremes, every opcode, zero divisor, unused opcodes, negate of minimum.
    send_op(CMD_ADD, maxw, minw, one, minw);
    send_op(CMD_ADD, minw, maxw, minw, maxw);
    send_op(CMD_SUB, minw, maxw, one, minw);
    send_op(CMD_SUB, one, one, one, one);
    send_op(CMD_MUL, maxw, maxw, maxw, maxw);
    send_op(CMD_MUL, minw, minw, minw, minw);
    send_op(CMD_MUL, one, -one, -one, one);
    send_op(CMD_MUL, 1, 0, 1, 0);
    send_op(CMD_MUL, -1, 0, 1, 0);
    send_op(CMD_DIV, one, one, 0, 0);
    send_op(CMD_DIV, maxw, minw, 1, 0);
    send_op(CMD_DIV, minw, minw, minw, minw);
    send_op(CMD_DIV, one, 0, 3 << FB, 0);
    send_op(CMD_DIV, -one, 0, 3 << FB, 0);
    send_op(CMD_DIV, 1, 1, maxw, maxw);
    send_op(CMD_NEG, minw, maxw, 0, 0);
    send_op(CMD_NEG, 0, 1, maxw, minw);
    for (k = 5; k != 0; k++) send_op(k, maxw, minw, maxw, minw);

    // Random: long hold-off early so the pipeline fills and stalls its input.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 40) hold_off = 1'b1;
      send_op(($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                           : 3'($urandom_range(0, 4)),
              rand_word(), rand_word(),
              ($urandom_range(0, 15) == 0) ? '0 : rand_word(),
              ($urandom_range(0, 15) == 0) ? '0 : rand_word());
    end
    s_tvalid <= 1'b0;

    while (board.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);

    $display("Sent %0d operand sets, checked %0d results (%0d saturated, %0d zero divisors).",
             sent, board.checked, board.sat_seen, board.div_zero_seen);
    if (board.mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches", board.mismatches);
      $display("Verification failed");
    end
    $finish;
  end

endmodule
